// File: sv/nibble_histogram_line_extrema_defines.svh
// Assertion macros for the nibble histogram block.
// Bodies compile away when SYNTHESIS is defined.
`ifndef NIBBLE_HISTOGRAM_LINE_EXTREMA_DEFINES_SVH
`define NIBBLE_HISTOGRAM_LINE_EXTREMA_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication.
`define NHLE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("nhle check failed: same-cycle implication");
// Next-cycle implication.
`define NHLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("nhle check failed: next-cycle implication");
`else
`define NHLE_ASSERT_NOW(lbl, clk, rstn, ante, cons)
`define NHLE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// File: sv/nhle_pkg.sv
// Shared constants, types and helper functions of the nibble histogram block.
// No dependencies.
package nhle_pkg;

    localparam int NUM_BINS       = 16;
    localparam int BIN_W          = 4;
    localparam int BYTE_W         = 8;
    localparam int COUNT_W        = 9;
    localparam int TOTAL_W        = 32;
    localparam int OUT_TOTAL_W    = 32;
    localparam int MAX_LINE_BYTES = 128;
    localparam int LEN_W          = $clog2(MAX_LINE_BYTES + 1);
    localparam int BPL_W          = 8;
    localparam int CMP_W          = ((LEN_W > BPL_W) ? LEN_W : BPL_W) + 1;
    localparam int APB_DATA_W     = 32;
    localparam int APB_ADDR_W     = 3;
    localparam int REG_SEL_BIT    = 2;

    localparam logic [BPL_W-1:0]  BPL_RESET = BPL_W'(128);
    localparam logic              REG_BPL   = 1'b0;
    localparam logic [BIN_W-1:0]  LAST_BIN  = BIN_W'(NUM_BINS - 1);
    localparam logic [BYTE_W-1:0] SIGN_MASK = 8'h80;

    typedef logic [COUNT_W-1:0] count_t;
    typedef logic [TOTAL_W-1:0] total_t;

    typedef enum logic {
        ST_TAKE,
        ST_EMIT
    } nhle_state_t;

    typedef struct packed {
        logic take;   // accept one byte and count it
        logic load;   // close one bin into the output register
    } nhle_cmd_t;

    typedef struct packed {
        logic line_end;  // byte at the input closes the line
        logic last_bin;  // bin 15 is next to close
        logic out_free;  // output register can take a beat this cycle
    } nhle_status_t;

    // Negative bytes become sign | magnitude; -128 stays 0x80.
    function automatic logic [BYTE_W-1:0] to_signmag(input logic [BYTE_W-1:0] raw);
        logic [BYTE_W-1:0] mag;
        mag = ~raw + BYTE_W'(1);
        return raw[BYTE_W-1] ? (SIGN_MASK | mag) : raw;
    endfunction

    // How many of the byte's two nibbles equal b (0..2).
    function automatic logic [1:0] nib_hits(input logic [BYTE_W-1:0] v,
                                            input logic [BIN_W-1:0] b);
        logic [1:0] hi;
        logic [1:0] lo;
        hi = {1'b0, (v[7:4] == b)};
        lo = {1'b0, (v[3:0] == b)};
        return hi + lo;
    endfunction

    function automatic count_t sat_add_count(input count_t c, input logic [1:0] k);
        logic [COUNT_W:0] sum;
        sum = {1'b0, c} + (COUNT_W+1)'(k);
        return sum[COUNT_W] ? '1 : sum[COUNT_W-1:0];
    endfunction

    function automatic total_t sat_add_total(input total_t t, input logic [1:0] k);
        logic [TOTAL_W:0] sum;
        sum = {1'b0, t} + (TOTAL_W+1)'(k);
        return sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
    endfunction

endpackage

// File: sv/nhle_ctrl.sv
// Controller of the nibble histogram block: take bytes, then close 16 bins.
// Depends on nhle_pkg.
module nhle_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  nhle_pkg::nhle_status_t status,
    output nhle_pkg::nhle_cmd_t    cmd
);

    nhle_pkg::nhle_state_t state_reg;
    nhle_pkg::nhle_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= nhle_pkg::ST_TAKE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            nhle_pkg::ST_TAKE: begin
                if (s_valid && status.line_end) begin
                    state_next = nhle_pkg::ST_EMIT;
                end
            end
            nhle_pkg::ST_EMIT: begin
                if (status.out_free && status.last_bin) begin
                    state_next = nhle_pkg::ST_TAKE;
                end
            end
            default: begin
                state_next = nhle_pkg::ST_TAKE;
            end
        endcase
    end

    always_comb begin
        s_ready  = 1'b0;
        cmd.take = 1'b0;
        cmd.load = 1'b0;
        case (state_reg)
            nhle_pkg::ST_TAKE: begin
                s_ready  = 1'b1;
                cmd.take = s_valid;
            end
            nhle_pkg::ST_EMIT: begin
                cmd.load = status.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: sv/nhle_dp.sv
// Datapath of the nibble histogram block: bin lanes, totals, extrema, output register.
// Depends on nhle_pkg.
module nhle_dp (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [nhle_pkg::BPL_W-1:0]            cfg_wdata,
    output logic [nhle_pkg::BPL_W-1:0]            cfg_bpl,
    input  nhle_pkg::nhle_cmd_t                    cmd,
    output nhle_pkg::nhle_status_t                 status,
    input  logic signed [nhle_pkg::BYTE_W-1:0]     s_data_byte,
    input  logic                                  m_ready,
    output logic                                  m_valid,
    output logic [nhle_pkg::BIN_W-1:0]            m_bin,
    output logic [nhle_pkg::COUNT_W-1:0]          m_line_count_twos,
    output logic [nhle_pkg::COUNT_W-1:0]          m_line_count_signmag,
    output logic [nhle_pkg::OUT_TOTAL_W-1:0]      m_total_twos,
    output logic [nhle_pkg::OUT_TOTAL_W-1:0]      m_total_signmag,
    output logic [nhle_pkg::COUNT_W-1:0]          m_most_twos,
    output logic [nhle_pkg::COUNT_W-1:0]          m_least_twos,
    output logic [nhle_pkg::COUNT_W-1:0]          m_most_signmag,
    output logic [nhle_pkg::COUNT_W-1:0]          m_least_signmag,
    output logic                                  m_last
);

    localparam int NB = nhle_pkg::NUM_BINS;

    logic [nhle_pkg::BPL_W-1:0] bpl_reg;
    logic [nhle_pkg::LEN_W-1:0] pos_reg;
    logic [nhle_pkg::LEN_W-1:0] pos_next;
    logic [nhle_pkg::BIN_W-1:0] idx_reg;

    nhle_pkg::count_t line_twos_reg [NB];
    nhle_pkg::count_t line_twos_next[NB];
    nhle_pkg::count_t line_sm_reg   [NB];
    nhle_pkg::count_t line_sm_next  [NB];
    nhle_pkg::total_t tot_twos_reg  [NB];
    nhle_pkg::total_t tot_twos_next [NB];
    nhle_pkg::total_t tot_sm_reg    [NB];
    nhle_pkg::total_t tot_sm_next   [NB];
    nhle_pkg::count_t max_twos_reg  [NB];
    nhle_pkg::count_t min_twos_reg  [NB];
    nhle_pkg::count_t max_sm_reg    [NB];
    nhle_pkg::count_t min_sm_reg    [NB];

    logic [nhle_pkg::BYTE_W-1:0] raw;
    logic [nhle_pkg::BYTE_W-1:0] sm;
    logic [nhle_pkg::CMP_W-1:0]  eff_len;
    logic [nhle_pkg::CMP_W-1:0]  pos_plus1;

    // selected bin while closing
    nhle_pkg::count_t ct_sel, cs_sel;
    nhle_pkg::count_t max_t_new, min_t_new, max_s_new, min_s_new;

    logic m_valid_reg;
    logic [nhle_pkg::BIN_W-1:0]       m_bin_reg;
    nhle_pkg::count_t                 m_ct_reg, m_cs_reg;
    logic [nhle_pkg::OUT_TOTAL_W-1:0] m_tt_reg, m_ts_reg;
    nhle_pkg::count_t                 m_mt_reg, m_lt_reg, m_ms_reg, m_ls_reg;
    logic                             m_last_reg;

    assign raw = s_data_byte;
    assign sm  = nhle_pkg::to_signmag(raw);

    // effective line length: 0 acts as 1, clip at the maximum
    always_comb begin
        if (bpl_reg == '0) begin
            eff_len = nhle_pkg::CMP_W'(1);
        end else if (nhle_pkg::CMP_W'(bpl_reg) > nhle_pkg::CMP_W'(nhle_pkg::MAX_LINE_BYTES)) begin
            eff_len = nhle_pkg::CMP_W'(nhle_pkg::MAX_LINE_BYTES);
        end else begin
            eff_len = nhle_pkg::CMP_W'(bpl_reg);
        end
    end

    assign pos_plus1 = nhle_pkg::CMP_W'(pos_reg) + nhle_pkg::CMP_W'(1);

    assign status.line_end = (pos_plus1 >= eff_len);
    assign status.last_bin = (idx_reg == nhle_pkg::LAST_BIN);
    assign status.out_free = !m_valid_reg || m_ready;

    assign ct_sel    = line_twos_reg[idx_reg];
    assign cs_sel    = line_sm_reg[idx_reg];
    assign max_t_new = (ct_sel > max_twos_reg[idx_reg]) ? ct_sel : max_twos_reg[idx_reg];
    assign min_t_new = (ct_sel < min_twos_reg[idx_reg]) ? ct_sel : min_twos_reg[idx_reg];
    assign max_s_new = (cs_sel > max_sm_reg[idx_reg]) ? cs_sel : max_sm_reg[idx_reg];
    assign min_s_new = (cs_sel < min_sm_reg[idx_reg]) ? cs_sel : min_sm_reg[idx_reg];

    always_comb begin
        pos_next = pos_reg;
        if (cmd.take) begin
            pos_next = status.line_end ? '0 : pos_reg + nhle_pkg::LEN_W'(1);
        end
    end

    // one lane per bin; a byte can hit the same bin twice
    always_comb begin
        for (int b = 0; b < NB; b++) begin
            line_twos_next[b] = line_twos_reg[b];
            line_sm_next[b]   = line_sm_reg[b];
            tot_twos_next[b]  = tot_twos_reg[b];
            tot_sm_next[b]    = tot_sm_reg[b];
            if (cmd.take) begin
                line_twos_next[b] = nhle_pkg::sat_add_count(line_twos_reg[b],
                                        nhle_pkg::nib_hits(raw, nhle_pkg::BIN_W'(b)));
                line_sm_next[b]   = nhle_pkg::sat_add_count(line_sm_reg[b],
                                        nhle_pkg::nib_hits(sm, nhle_pkg::BIN_W'(b)));
                tot_twos_next[b]  = nhle_pkg::sat_add_total(tot_twos_reg[b],
                                        nhle_pkg::nib_hits(raw, nhle_pkg::BIN_W'(b)));
                tot_sm_next[b]    = nhle_pkg::sat_add_total(tot_sm_reg[b],
                                        nhle_pkg::nib_hits(sm, nhle_pkg::BIN_W'(b)));
            end
            if (cmd.load && (idx_reg == nhle_pkg::BIN_W'(b))) begin
                line_twos_next[b] = '0;
                line_sm_next[b]   = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bpl_reg     <= nhle_pkg::BPL_RESET;
            pos_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int b = 0; b < NB; b++) begin
                line_twos_reg[b] <= '0;
                line_sm_reg[b]   <= '0;
                tot_twos_reg[b]  <= '0;
                tot_sm_reg[b]    <= '0;
                max_twos_reg[b]  <= '0;
                max_sm_reg[b]    <= '0;
                min_twos_reg[b]  <= '1;
                min_sm_reg[b]    <= '1;
            end
        end else begin
            if (cfg_we) begin
                bpl_reg <= cfg_wdata;
            end
            pos_reg <= pos_next;
            for (int b = 0; b < NB; b++) begin
                line_twos_reg[b] <= line_twos_next[b];
                line_sm_reg[b]   <= line_sm_next[b];
                tot_twos_reg[b]  <= tot_twos_next[b];
                tot_sm_reg[b]    <= tot_sm_next[b];
            end
            if (cmd.load) begin
                max_twos_reg[idx_reg] <= max_t_new;
                min_twos_reg[idx_reg] <= min_t_new;
                max_sm_reg[idx_reg]   <= max_s_new;
                min_sm_reg[idx_reg]   <= min_s_new;
                idx_reg               <= idx_reg + nhle_pkg::BIN_W'(1);
                m_valid_reg           <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // output payload, no reset
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            m_bin_reg  <= idx_reg;
            m_ct_reg   <= ct_sel;
            m_cs_reg   <= cs_sel;
            m_tt_reg   <= tot_twos_reg[idx_reg][nhle_pkg::OUT_TOTAL_W-1:0];
            m_ts_reg   <= tot_sm_reg[idx_reg][nhle_pkg::OUT_TOTAL_W-1:0];
            m_mt_reg   <= max_t_new;
            m_lt_reg   <= min_t_new;
            m_ms_reg   <= max_s_new;
            m_ls_reg   <= min_s_new;
            m_last_reg <= (idx_reg == nhle_pkg::LAST_BIN);
        end
    end

    assign cfg_bpl              = bpl_reg;
    assign m_valid              = m_valid_reg;
    assign m_bin                = m_bin_reg;
    assign m_line_count_twos    = m_ct_reg;
    assign m_line_count_signmag = m_cs_reg;
    assign m_total_twos         = m_tt_reg;
    assign m_total_signmag      = m_ts_reg;
    assign m_most_twos          = m_mt_reg;
    assign m_least_twos         = m_lt_reg;
    assign m_most_signmag       = m_ms_reg;
    assign m_least_signmag      = m_ls_reg;
    assign m_last               = m_last_reg;

endmodule

// File: sv/nibble_histogram_line_extrema.sv
// Top level of the nibble histogram block; uses nhle_pkg, nhle_ctrl, nhle_dp and the defines header.
// Rate: one byte per cycle inside a line; the closing byte then starts a 16-beat burst, one bin
// per cycle while m_ready is high. First beat: state register moves to EMIT, then bin 0 is loaded
// into the output register and shown; output register frees input.
// Reset (aresetn, synchronous, low): line counts, totals, maxima clear, minima go to all ones,
// bytes_per_line returns to 128, byte position and bin index to zero.
`include "nibble_histogram_line_extrema_defines.svh"
module nibble_histogram_line_extrema (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // APB-style configuration port
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [nhle_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [nhle_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [nhle_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    // byte input
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic signed [nhle_pkg::BYTE_W-1:0]     s_data_byte,
    // per-bin results
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic [nhle_pkg::BIN_W-1:0]            m_bin,
    output logic [nhle_pkg::COUNT_W-1:0]          m_line_count_twos,
    output logic [nhle_pkg::COUNT_W-1:0]          m_line_count_signmag,
    output logic [nhle_pkg::OUT_TOTAL_W-1:0]      m_total_twos,
    output logic [nhle_pkg::OUT_TOTAL_W-1:0]      m_total_signmag,
    output logic [nhle_pkg::COUNT_W-1:0]          m_most_twos,
    output logic [nhle_pkg::COUNT_W-1:0]          m_least_twos,
    output logic [nhle_pkg::COUNT_W-1:0]          m_most_signmag,
    output logic [nhle_pkg::COUNT_W-1:0]          m_least_signmag,
    output logic                                  m_last
);

    nhle_pkg::nhle_cmd_t    cmd;
    nhle_pkg::nhle_status_t status;

    logic                       cfg_we;
    logic                       reg_sel_bpl;
    logic [nhle_pkg::BPL_W-1:0] cfg_bpl;

    // Only one register: paddr bit 2 picks the word, byte offsets are don't-care.
    assign reg_sel_bpl = (paddr[nhle_pkg::REG_SEL_BIT] == nhle_pkg::REG_BPL);
    assign pready      = 1'b1;
    assign cfg_we      = psel && penable && pwrite && pready && reg_sel_bpl;
    assign prdata      = reg_sel_bpl ? nhle_pkg::APB_DATA_W'(cfg_bpl) : '0;

    // Controller: TAKE accepts bytes, EMIT closes bins 0..15 into the output register.
    nhle_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Datapath: 16 bin lanes per encoding, extrema update on the closing bin, result beat.
    nhle_dp u_dp (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_we),
        .cfg_wdata            (pwdata[nhle_pkg::BPL_W-1:0]),
        .cfg_bpl              (cfg_bpl),
        .cmd                  (cmd),
        .status               (status),
        .s_data_byte          (s_data_byte),
        .m_ready              (m_ready),
        .m_valid              (m_valid),
        .m_bin                (m_bin),
        .m_line_count_twos    (m_line_count_twos),
        .m_line_count_signmag (m_line_count_signmag),
        .m_total_twos         (m_total_twos),
        .m_total_signmag      (m_total_signmag),
        .m_most_twos          (m_most_twos),
        .m_least_twos         (m_least_twos),
        .m_most_signmag       (m_most_signmag),
        .m_least_signmag      (m_least_signmag),
        .m_last               (m_last)
    );

    // A taken non-last bin beat is followed at once by the next bin.
    `NHLE_ASSERT_NEXT(a_bin_follows, aclk, aresetn, m_valid && m_ready && !m_last, m_valid && (m_bin == 4'($past(m_bin) + 4'd1)))
    // Every beat's line count lies between the least and most counts it carries.
    `NHLE_ASSERT_NOW(a_extrema_bound, aclk, aresetn, m_valid, (m_least_twos <= m_line_count_twos) && (m_line_count_twos <= m_most_twos) && (m_least_signmag <= m_line_count_signmag) && (m_line_count_signmag <= m_most_signmag))
    // The byte that closes a line stops intake for the burst.
    `NHLE_ASSERT_NEXT(a_close_stalls, aclk, aresetn, s_valid && s_ready && status.line_end, !s_ready)
    // Bins before the last are only shown while the burst is running.
    `NHLE_ASSERT_NOW(a_burst_no_intake, aclk, aresetn, m_valid && !m_last, !s_ready)

endmodule

// File: tb/nibble_histogram_line_extrema_tb.sv
// Self-checking testbench for nibble_histogram_line_extrema: byte stream in, 16 bin reports out.
// Depends on nhle_pkg and the block's RTL; the expected bin reports come from an in-bench model.
`timescale 1ns / 100ps
module nibble_histogram_line_extrema_tb;
    import nhle_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;    // margin on top once every queued byte and owed report has gone
    localparam logic [APB_ADDR_W-1:0] ADDR_BYTES_PER_LINE = APB_ADDR_W'(0);

    // One expected beat on the result channel.
    typedef struct {
        logic [BIN_W-1:0] bin;
        count_t           line_twos;
        count_t           line_sm;
        total_t           tot_twos;
        total_t           tot_sm;
        count_t           most_twos;
        count_t           least_twos;
        count_t           most_sm;
        count_t           least_sm;
        logic             last;
    } bin_report_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [APB_ADDR_W-1:0]      paddr = '0;
    logic [APB_DATA_W-1:0]      pwdata = '0;
    logic [APB_DATA_W-1:0]      prdata;
    logic                       pready;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    logic signed [BYTE_W-1:0]   s_data_byte = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic [BIN_W-1:0]           m_bin;
    logic [COUNT_W-1:0]         m_line_count_twos;
    logic [COUNT_W-1:0]         m_line_count_signmag;
    logic [OUT_TOTAL_W-1:0]     m_total_twos;
    logic [OUT_TOTAL_W-1:0]     m_total_signmag;
    logic [COUNT_W-1:0]         m_most_twos;
    logic [COUNT_W-1:0]         m_least_twos;
    logic [COUNT_W-1:0]         m_most_signmag;
    logic [COUNT_W-1:0]         m_least_signmag;
    logic                       m_last;

    nibble_histogram_line_extrema dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_data_byte          (s_data_byte),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_bin                (m_bin),
        .m_line_count_twos    (m_line_count_twos),
        .m_line_count_signmag (m_line_count_signmag),
        .m_total_twos         (m_total_twos),
        .m_total_signmag      (m_total_signmag),
        .m_most_twos          (m_most_twos),
        .m_least_twos         (m_least_twos),
        .m_most_signmag       (m_most_signmag),
        .m_least_signmag      (m_least_signmag),
        .m_last               (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Histogram model state, mirrors the block after reset
    // ---------------------------------------------------------------
    logic [BPL_W-1:0] line_len_cfg = BPL_RESET;
    int               bytes_in_line = 0;
    count_t           line_twos [NUM_BINS];
    count_t           line_sm   [NUM_BINS];
    total_t           tot_twos  [NUM_BINS];
    total_t           tot_sm    [NUM_BINS];
    count_t           most_twos [NUM_BINS];
    count_t           least_twos[NUM_BINS];
    count_t           most_sm   [NUM_BINS];
    count_t           least_sm  [NUM_BINS];

    bin_report_t      report_q[$];     // bin reports still owed by the block
    logic [7:0]       byte_q[$];       // bytes waiting for the driver

    int fail_cnt = 0;
    int bytes_taken = 0;
    int beats_seen = 0;
    int lines_closed = 0;
    int settings_used = 0;
    int cycle_cnt = 0;
    int sender_idle_pct = 0;
    int recv_stall_pct = 0;

    initial begin
        for (int b = 0; b < NUM_BINS; b++) begin
            line_twos[b]  = '0;
            line_sm[b]    = '0;
            tot_twos[b]   = '0;
            tot_sm[b]     = '0;
            most_twos[b]  = '0;
            most_sm[b]    = '0;
            least_twos[b] = '1;   // minima start at the all-ones sentinel
            least_sm[b]   = '1;
        end
    end

    // Append one byte to the driver's queue.
    task automatic add_byte(input logic [7:0] value);
        byte_q.insert(byte_q.size(), value);
    endtask

    // Count one accepted byte; on the line's closing byte queue the 16 bin reports.
    task automatic tally_byte(input logic [7:0] raw);
        logic [7:0]       sm;
        logic [7:0]       mag;
        logic [BIN_W-1:0] nt;
        logic [BIN_W-1:0] ns;
        int               eff_len;
        bin_report_t      rep;
        mag = 8'(9'h100 - {1'b0, raw});
        sm = raw[7] ? (8'h80 | mag) : raw;   // -128 lands on 0x80
        for (int k = 0; k < 2; k++) begin
            nt = k ? raw[3:0] : raw[7:4];
            ns = k ? sm[3:0] : sm[7:4];
            if (line_twos[nt] != '1) line_twos[nt] = line_twos[nt] + 1'b1;
            if (tot_twos[nt] != '1) tot_twos[nt] = tot_twos[nt] + 1'b1;
            if (line_sm[ns] != '1) line_sm[ns] = line_sm[ns] + 1'b1;
            if (tot_sm[ns] != '1) tot_sm[ns] = tot_sm[ns] + 1'b1;
        end
        // zero acts as one, anything past the line buffer acts as its size
        eff_len = (line_len_cfg == 0) ? 1 :
                  (int'(line_len_cfg) > MAX_LINE_BYTES) ? MAX_LINE_BYTES : int'(line_len_cfg);
        if (bytes_in_line + 1 < eff_len) begin
            bytes_in_line++;
        end else begin
            for (int b = 0; b < NUM_BINS; b++) begin
                if (line_twos[b] > most_twos[b]) most_twos[b] = line_twos[b];
                if (line_twos[b] < least_twos[b]) least_twos[b] = line_twos[b];
                if (line_sm[b] > most_sm[b]) most_sm[b] = line_sm[b];
                if (line_sm[b] < least_sm[b]) least_sm[b] = line_sm[b];
                rep.bin        = BIN_W'(b);
                rep.line_twos  = line_twos[b];
                rep.line_sm    = line_sm[b];
                rep.tot_twos   = tot_twos[b];
                rep.tot_sm     = tot_sm[b];
                rep.most_twos  = most_twos[b];
                rep.least_twos = least_twos[b];
                rep.most_sm    = most_sm[b];
                rep.least_sm   = least_sm[b];
                rep.last       = (b == NUM_BINS - 1);
                report_q.insert(report_q.size(), rep);
                line_twos[b] = '0;
                line_sm[b]   = '0;
            end
            bytes_in_line = 0;
            lines_closed++;
        end
    endtask

    // Idle decision; no idling at all while cycle_cnt bits 7:6 are both set, one window in four.
    function automatic bit idle_roll(input int pct);
        if (cycle_cnt[7:6] == 2'b11) return 1'b0;
        return $urandom_range(99) < pct;
    endfunction

    // ---------------------------------------------------------------
    // Byte driver: holds each beat until taken, gaps at sender_idle_pct
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                tally_byte(s_data_byte);
                bytes_taken++;
            end
            if (!s_valid || s_ready) begin
                if (byte_q.size() > 0 && !idle_roll(sender_idle_pct)) begin
                    s_valid     <= 1'b1;
                    s_data_byte <= byte_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Result monitor: compares each taken beat with the oldest report
    // ---------------------------------------------------------------
    task automatic check_field(input string name, input logic [31:0] exp, input logic [31:0] act);
        if (exp !== act) begin
            $error("%s: expected %0d, got %0d", name, exp, act);
            fail_cnt++;
        end
    endtask

    always @(posedge aclk) begin
        bin_report_t rep;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                beats_seen++;
                if (report_q.size() == 0) begin
                    $error("result beat for bin %0d with no report pending", m_bin);
                    fail_cnt++;
                end else begin
                    rep = report_q.pop_front();
                    check_field("bin", 32'(rep.bin), 32'(m_bin));
                    check_field("line_count_twos", 32'(rep.line_twos), 32'(m_line_count_twos));
                    check_field("line_count_signmag", 32'(rep.line_sm), 32'(m_line_count_signmag));
                    check_field("total_twos", rep.tot_twos, m_total_twos);
                    check_field("total_signmag", rep.tot_sm, m_total_signmag);
                    check_field("most_twos", 32'(rep.most_twos), 32'(m_most_twos));
                    check_field("least_twos", 32'(rep.least_twos), 32'(m_least_twos));
                    check_field("most_signmag", 32'(rep.most_sm), 32'(m_most_signmag));
                    check_field("least_signmag", 32'(rep.least_sm), 32'(m_least_signmag));
                    check_field("last", 32'(rep.last), 32'(m_last));
                end
            end
            m_ready <= !idle_roll(recv_stall_pct);
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Sequencing helpers
    // ---------------------------------------------------------------
    // Setup cycle, then access cycle; register takes the value at the access edge.
    task automatic write_line_len(input logic [BPL_W-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BYTES_PER_LINE;
        pwdata  <= APB_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        line_len_cfg = value;
        settings_used++;
    endtask

    // Wait for every queued byte to go in and every owed report to come out.
    task automatic drain;
        while (byte_q.size() > 0 || s_valid || report_q.size() > 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_byte;
        case ($urandom_range(7))
            0: return 8'h80;   // -128
            1: return 8'h7F;
            2: return 8'hFF;
            3: return 8'h00;
            default: return 8'($urandom);
        endcase
    endfunction

    initial begin
        logic [BPL_W-1:0] seg_len [8];
        logic [7:0]       corner_bytes [12];
        int               eff;
        int               n_items;
        seg_len = '{8'd3, 8'd1, 8'd9, 8'd128, 8'd6, 8'd0, 8'd13, 8'd255};
        corner_bytes = '{8'h80, 8'h7F, 8'h00, 8'hFF, 8'h01, 8'h0F, 8'hF0, 8'h81,
                         8'h55, 8'hAA, 8'h11, 8'h88};

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: two bytes at the reset length of 128, then drop to 0 so the
        // next byte closes that line at once (zero behaves as one).
        add_byte(8'h00);
        add_byte(8'hFF);
        drain();
        write_line_len(8'd0);
        // one-byte lines over the field extremes and nibble corners
        foreach (corner_bytes[i])
            add_byte(corner_bytes[i]);
        drain();
        // length lowered below the bytes already in the line: next byte closes it
        write_line_len(8'd5);
        add_byte(8'h80);
        add_byte(8'h7F);
        add_byte(8'h33);
        drain();
        write_line_len(8'd2);
        add_byte(8'h44);
        drain();

        // Random segments; each idling mode gets two different line lengths.
        for (int seg = 0; seg < 8; seg++) begin
            case (seg / 2)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 72; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 72; end
                default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            write_line_len(seg_len[seg]);
            eff = (seg_len[seg] == 0) ? 1 :
                  (int'(seg_len[seg]) > MAX_LINE_BYTES) ? MAX_LINE_BYTES : int'(seg_len[seg]);
            // long lines get one full line plus a stub of zero to three bytes left open across the next write
            n_items = (eff >= 64) ? eff + $urandom_range(3) : 25;
            for (int i = 0; i < n_items; i++) add_byte(pick_byte());
            drain();
        end

        $display("run covered %0d bytes, %0d closed lines, %0d result beats",
                 bytes_taken, lines_closed, beats_seen);
        $display("line length written %0d times, four idling modes", settings_used);
        if (fail_cnt == 0 && report_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/nhle_pkg.sv
sv/nhle_ctrl.sv
sv/nhle_dp.sv
sv/nibble_histogram_line_extrema.sv
tb/nibble_histogram_line_extrema_tb.sv
